>>> hdl/ict_pkg.sv
`timescale 1ns / 1ps
package ict_pkg;

   // Store geometry
   localparam int unsigned CAPACITY  = 32;
   localparam int unsigned IDX_W     = $clog2(CAPACITY);
   localparam int unsigned CNT_W     = 6;
   localparam int unsigned GAP_LIMIT = CAPACITY + 1;

   // Request codes
   localparam logic [2:0] REQ_ADD     = 3'd0;
   localparam logic [2:0] REQ_MEMBER  = 3'd1;
   localparam logic [2:0] REQ_COUNT   = 3'd2;
   localparam logic [2:0] REQ_GAPS    = 3'd3;
   localparam logic [2:0] REQ_LARGEST = 3'd4;
   localparam logic [2:0] REQ_CLEAR   = 3'd5;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVERTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // Saturation points
   localparam logic [32:0] TOTAL_CAP = 33'h1_0000_0000;
   localparam logic [32:0] GAP_SAT   = 33'h0_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] lo_index;
      logic [31:0] hi_index;
      logic [6:0]  max_gaps;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [32:0] answer;
      logic [31:0] gap_first;
      logic [31:0] gap_last;
      logic        last_result;
      logic [32:0] total_covered;
      logic [5:0]  interval_count;
      logic [31:0] dropped_count;
      logic        overflow_flag;
      logic [31:0] bound_low;
      logic [31:0] bound_high;
   } rsp_item_type;

   // Datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_BAD,
      OP_ADD_START,
      OP_ADD_FIRST,
      OP_TAIL,
      OP_APPEND,
      OP_CO_INIT,
      OP_CO_SCAN,
      OP_CO_MERGE,
      OP_COPY,
      OP_CO_DONE,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_MG_WRITE,
      OP_MG_DONE,
      OP_INS_INIT,
      OP_INS,
      OP_MEMBER,
      OP_COUNT,
      OP_GAP,
      OP_GAP_TAIL,
      OP_CLEAR,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       inverted;
      logic       store_empty;
      logic       store_full;
      logic       scan_end;
      logic       tail_extend;
      logic       tail_after;
      logic       scan_stop;
      logic       merge_found;
      logic       co_last;
      logic       ins_done;
      logic       gap_stop;
      logic       out_free;
   } dp_status_type;

   // Number of indices in an inclusive interval
   function automatic logic [32:0] span(input logic [31:0] first, input logic [31:0] last);
      return {1'b0, last} - {1'b0, first} + 33'd1;
   endfunction

endpackage

>>> hdl/ict_datapath.sv
`timescale 1ns / 1ps
module ict_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ict_pkg::dp_cmd_type   cmd,
   output ict_pkg::dp_status_type dp_status,
   input  ict_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ict_pkg::rsp_item_type rsp_item
);

   localparam int unsigned CW = ict_pkg::CNT_W;
   localparam int unsigned IW = ict_pkg::IDX_W;

   // Interval store
   logic [31:0] store_first_ff [ict_pkg::CAPACITY];
   logic [31:0] store_last_ff  [ict_pkg::CAPACITY];

   // Architectural state
   logic [CW-1:0] count_ff, count_in;
   logic [32:0]   total_ff, total_in;
   logic [31:0]   drop_ff, drop_in;
   logic          ovf_ff, ovf_in;
   logic          bseen_ff, bseen_in;
   logic [31:0]   blo_ff, blo_in;
   logic [31:0]   bhi_ff, bhi_in;

   // Request and working registers
   logic [2:0]    kind_ff, kind_in;
   logic [31:0]   a_ff, a_in;
   logic [31:0]   b_ff, b_in;
   logic [6:0]    limit_ff, limit_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] me_ff, me_in;
   logic [CW-1:0] shift_ff, shift_in;
   logic [CW-1:0] best_ff, best_in;
   logic [32:0]   min_gap_ff, min_gap_in;
   logic [31:0]   prev_ff, prev_in;
   logic [31:0]   mf_ff, mf_in;
   logic [31:0]   ml_ff, ml_in;
   logic [37:0]   before_ff, before_in;
   logic [32:0]   acc_ff, acc_in;
   logic          hit_ff, hit_in;
   logic [32:0]   cursor_ff, cursor_in;
   logic [32:0]   largest_ff, largest_in;
   logic [6:0]    written_ff, written_in;
   logic          pend_v_ff, pend_v_in;
   logic [31:0]   pend_first_ff, pend_first_in;
   logic [31:0]   pend_last_ff, pend_last_in;
   logic [1:0]    stcode_ff, stcode_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ict_pkg::rsp_item_type rsp_ff, rsp_in;

   // Store access
   logic [CW-1:0] rd_addr;
   logic [31:0]   rd_first, rd_last;
   logic          wr_en, wr_first_en;
   logic [CW-1:0] wr_addr;
   logic [31:0]   wr_first, wr_last;

   // Shared arithmetic
   logic [32:0]   next_cur, g_width, tail_width, co_gap, add_val, sum_bound;
   logic [33:0]   total_sum;
   logic [37:0]   merge_diff;
   logic          g_hit, out_free, add_en, emit_gap, emit_final, co_better;
   logic [CW-1:0] best_sel;
   logic [31:0]   win_lo, win_hi;

   assign rd_addr  = (cmd.op == ict_pkg::OP_INS) ? idx_ff - CW'(1) : idx_ff;
   assign rd_first = store_first_ff[rd_addr[IW-1:0]];
   assign rd_last  = store_last_ff[rd_addr[IW-1:0]];

   assign next_cur   = {1'b0, rd_last} + 33'd1;
   assign g_hit      = {1'b0, rd_first} > cursor_ff;
   assign g_width    = {1'b0, rd_first} - cursor_ff;
   assign tail_width = {1'b0, b_ff} - cursor_ff + 33'd1;
   assign co_gap     = {1'b0, rd_first} - {1'b0, prev_ff};
   assign co_better  = (idx_ff != '0) && (co_gap < min_gap_ff);
   assign best_sel   = co_better ? idx_ff - CW'(1) : best_ff;
   assign sum_bound  = {1'b0, b_ff} + 33'd1;
   assign merge_diff = {5'b0, ict_pkg::span(mf_ff, ml_ff)} - before_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign win_lo     = (rd_first > a_ff) ? rd_first : a_ff;
   assign win_hi     = (rd_last < b_ff) ? rd_last : b_ff;

   // Status to the controller
   always_comb begin
      dp_status.kind        = kind_ff;
      dp_status.inverted    = a_ff > b_ff;
      dp_status.store_empty = count_ff == '0;
      dp_status.store_full  = count_ff >= CW'(ict_pkg::CAPACITY);
      dp_status.scan_end    = idx_ff >= count_ff;
      dp_status.tail_extend = (a_ff >= rd_first) && ({1'b0, a_ff} <= next_cur);
      dp_status.tail_after  = {1'b0, a_ff} > next_cur;
      dp_status.scan_stop   = (next_cur >= {1'b0, a_ff}) && ({1'b0, rd_first} > sum_bound);
      dp_status.merge_found = me_ff > pos_ff;
      dp_status.co_last     = idx_ff == count_ff - CW'(1);
      dp_status.ins_done    = idx_ff == pos_ff;
      dp_status.gap_stop    = (written_ff >= limit_ff) || ((rd_last >= a_ff) && (rd_first > b_ff));
      dp_status.out_free    = out_free;
   end

   // Operation decode
   always_comb begin
      count_in = count_ff;   total_in = total_ff;     drop_in = drop_ff;
      ovf_in = ovf_ff;       bseen_in = bseen_ff;     blo_in = blo_ff;     bhi_in = bhi_ff;
      kind_in = kind_ff;     a_in = a_ff;             b_in = b_ff;         limit_in = limit_ff;
      idx_in = idx_ff;       pos_in = pos_ff;         me_in = me_ff;       shift_in = shift_ff;
      best_in = best_ff;     min_gap_in = min_gap_ff; prev_in = prev_ff;
      mf_in = mf_ff;         ml_in = ml_ff;           before_in = before_ff;
      acc_in = acc_ff;       hit_in = hit_ff;         cursor_in = cursor_ff;
      largest_in = largest_ff; written_in = written_ff; pend_v_in = pend_v_ff;
      pend_first_in = pend_first_ff; pend_last_in = pend_last_ff; stcode_in = stcode_ff;
      wr_en = 1'b0;  wr_first_en = 1'b1;  wr_addr = idx_ff;
      wr_first = rd_first;  wr_last = rd_last;
      add_en = 1'b0;  add_val = '0;  emit_gap = 1'b0;  emit_final = 1'b0;

      unique case (cmd.op)
         ict_pkg::OP_NONE: begin
         end
         ict_pkg::OP_LOAD: begin
            kind_in = req_item.req_type;
            a_in    = req_item.lo_index;
            b_in    = req_item.hi_index;
            if (req_item.req_type == ict_pkg::REQ_LARGEST ||
                req_item.max_gaps > 7'(ict_pkg::GAP_LIMIT)) begin
               limit_in = 7'(ict_pkg::GAP_LIMIT);
            end else begin
               limit_in = req_item.max_gaps;
            end
            idx_in = '0;  acc_in = '0;  hit_in = 1'b0;
            cursor_in = {1'b0, req_item.lo_index};
            largest_in = '0;  written_in = '0;  pend_v_in = 1'b0;
            stcode_in = ict_pkg::STATUS_OK;
         end
         ict_pkg::OP_BAD: begin
            stcode_in = ict_pkg::STATUS_INVERTED;
         end
         ict_pkg::OP_ADD_START: begin
            bseen_in = 1'b1;
            blo_in = (!bseen_ff || a_ff < blo_ff) ? a_ff : blo_ff;
            bhi_in = (!bseen_ff || b_ff > bhi_ff) ? b_ff : bhi_ff;
            idx_in = (count_ff == '0) ? '0 : count_ff - CW'(1);
         end
         ict_pkg::OP_ADD_FIRST: begin
            wr_en = 1'b1;  wr_addr = '0;  wr_first = a_ff;  wr_last = b_ff;
            count_in = CW'(1);
            add_en = 1'b1;  add_val = ict_pkg::span(a_ff, b_ff);
         end
         ict_pkg::OP_TAIL: begin
            if (b_ff > rd_last) begin
               wr_en = 1'b1;  wr_first_en = 1'b0;  wr_last = b_ff;
               add_en = 1'b1;  add_val = {1'b0, b_ff} - {1'b0, rd_last};
            end
         end
         ict_pkg::OP_APPEND: begin
            wr_en = 1'b1;  wr_addr = count_ff;  wr_first = a_ff;  wr_last = b_ff;
            count_in = count_ff + CW'(1);
            add_en = 1'b1;  add_val = ict_pkg::span(a_ff, b_ff);
         end
         ict_pkg::OP_CO_INIT: begin
            idx_in = '0;  best_in = '0;  min_gap_in = '1;
         end
         ict_pkg::OP_CO_SCAN: begin
            if (co_better) begin
               best_in = best_sel;
               min_gap_in = co_gap;
            end
            prev_in = rd_last;
            idx_in = (idx_ff == count_ff - CW'(1)) ? best_sel + CW'(1) : idx_ff + CW'(1);
         end
         ict_pkg::OP_CO_MERGE: begin
            // last of the closer pair absorbs the next interval
            wr_en = 1'b1;  wr_first_en = 1'b0;  wr_addr = best_ff;  wr_last = rd_last;
            shift_in = CW'(1);
            idx_in = idx_ff + CW'(1);
         end
         ict_pkg::OP_COPY: begin
            wr_en = 1'b1;  wr_addr = idx_ff - shift_ff;
            idx_in = idx_ff + CW'(1);
         end
         ict_pkg::OP_CO_DONE: begin
            count_in = count_ff - CW'(1);
            drop_in = (drop_ff == '1) ? drop_ff : drop_ff + 32'd1;
            ovf_in = 1'b1;
            idx_in = '0;  pos_in = '0;  me_in = '0;
            mf_in = a_ff;  ml_in = b_ff;  before_in = '0;
         end
         ict_pkg::OP_SCAN_INIT: begin
            idx_in = '0;  pos_in = '0;  me_in = '0;
            mf_in = a_ff;  ml_in = b_ff;  before_in = '0;
         end
         ict_pkg::OP_SCAN: begin
            if (next_cur < {1'b0, a_ff}) begin
               pos_in = idx_ff + CW'(1);
               me_in  = idx_ff + CW'(1);
            end else begin
               me_in = idx_ff + CW'(1);
               if (rd_first < mf_ff) mf_in = rd_first;
               if (rd_last > ml_ff) ml_in = rd_last;
               before_in = before_ff + {5'b0, ict_pkg::span(rd_first, rd_last)};
            end
            idx_in = idx_ff + CW'(1);
         end
         ict_pkg::OP_MG_WRITE: begin
            wr_en = 1'b1;  wr_addr = pos_ff;  wr_first = mf_ff;  wr_last = ml_ff;
            shift_in = me_ff - pos_ff - CW'(1);
            idx_in = me_ff;
         end
         ict_pkg::OP_MG_DONE: begin
            count_in = count_ff - shift_ff;
            add_en = 1'b1;  add_val = merge_diff[32:0];
         end
         ict_pkg::OP_INS_INIT: begin
            idx_in = count_ff;
         end
         ict_pkg::OP_INS: begin
            if (idx_ff == pos_ff) begin
               wr_en = 1'b1;  wr_addr = pos_ff;  wr_first = a_ff;  wr_last = b_ff;
               count_in = count_ff + CW'(1);
               add_en = 1'b1;  add_val = ict_pkg::span(a_ff, b_ff);
            end else begin
               // open a slot: entry below moves up one
               wr_en = 1'b1;  wr_addr = idx_ff;
               idx_in = idx_ff - CW'(1);
            end
         end
         ict_pkg::OP_MEMBER: begin
            if (a_ff >= rd_first && a_ff <= rd_last) hit_in = 1'b1;
            idx_in = idx_ff + CW'(1);
         end
         ict_pkg::OP_COUNT: begin
            if (win_lo <= win_hi) acc_in = acc_ff + ict_pkg::span(win_lo, win_hi);
            idx_in = idx_ff + CW'(1);
         end
         ict_pkg::OP_GAP: begin
            if (rd_last < a_ff) begin
               idx_in = idx_ff + CW'(1);
            end else if (!(g_hit && kind_ff == ict_pkg::REQ_GAPS && pend_v_ff && !out_free)) begin
               if (g_hit) begin
                  if (g_width > largest_ff) largest_in = g_width;
                  written_in = written_ff + 7'd1;
                  emit_gap = pend_v_ff && (kind_ff == ict_pkg::REQ_GAPS);
                  pend_v_in = 1'b1;
                  pend_first_in = cursor_ff[31:0];
                  pend_last_in = rd_first - 32'd1;
               end
               if (next_cur > cursor_ff) cursor_in = next_cur;
               idx_in = idx_ff + CW'(1);
            end
         end
         ict_pkg::OP_GAP_TAIL: begin
            if (written_ff < limit_ff && cursor_ff <= {1'b0, b_ff}) begin
               if (tail_width > largest_ff) largest_in = tail_width;
               written_in = written_ff + 7'd1;
               emit_gap = pend_v_ff && (kind_ff == ict_pkg::REQ_GAPS);
               pend_v_in = 1'b1;
               pend_first_in = cursor_ff[31:0];
               pend_last_in = b_ff;
            end
         end
         ict_pkg::OP_CLEAR: begin
            count_in = '0;  total_in = '0;  drop_in = '0;  ovf_in = 1'b0;
            bseen_in = 1'b0;  blo_in = '0;  bhi_in = '0;
         end
         ict_pkg::OP_EMIT: begin
            emit_final = 1'b1;
         end
         default: begin
         end
      endcase

      // Saturating covered total
      total_sum = {1'b0, total_ff} + {1'b0, add_val};
      if (add_en) begin
         total_in = (total_sum > {1'b0, ict_pkg::TOTAL_CAP}) ? ict_pkg::TOTAL_CAP : total_sum[32:0];
      end

      // Result register
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit_gap || emit_final) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = ict_pkg::STATUS_OK;
         rsp_in.found          = 1'b0;
         rsp_in.answer         = '0;
         rsp_in.gap_first      = '0;
         rsp_in.gap_last       = '0;
         rsp_in.last_result    = emit_final;
         rsp_in.total_covered  = total_ff;
         rsp_in.interval_count = count_ff;
         rsp_in.dropped_count  = drop_ff;
         rsp_in.overflow_flag  = ovf_ff;
         rsp_in.bound_low      = blo_ff;
         rsp_in.bound_high     = bhi_ff;
         if (emit_gap || (kind_ff == ict_pkg::REQ_GAPS && pend_v_ff)) begin
            rsp_in.found     = 1'b1;
            rsp_in.gap_first = pend_first_ff;
            rsp_in.gap_last  = pend_last_ff;
         end else begin
            case (kind_ff)
               ict_pkg::REQ_ADD:     rsp_in.status = stcode_ff;
               ict_pkg::REQ_MEMBER:  rsp_in.found  = hit_ff;
               ict_pkg::REQ_COUNT:   rsp_in.answer = acc_ff;
               ict_pkg::REQ_LARGEST: rsp_in.answer = (largest_ff > ict_pkg::GAP_SAT) ?
                                                     ict_pkg::GAP_SAT : largest_ff;
               default: begin
               end
            endcase
         end
      end
   end

   // Store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_first_en) store_first_ff[wr_addr[IW-1:0]] <= wr_first;
         store_last_ff[wr_addr[IW-1:0]] <= wr_last;
      end
   end

   // Control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;  total_ff <= '0;  drop_ff <= '0;  ovf_ff <= 1'b0;
         bseen_ff <= 1'b0;  blo_ff <= '0;  bhi_ff <= '0;  rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;  total_ff <= total_in;  drop_ff <= drop_in;  ovf_ff <= ovf_in;
         bseen_ff <= bseen_in;  blo_ff <= blo_in;  bhi_ff <= bhi_in;  rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;  a_ff <= a_in;  b_ff <= b_in;  limit_ff <= limit_in;
      idx_ff <= idx_in;  pos_ff <= pos_in;  me_ff <= me_in;  shift_ff <= shift_in;
      best_ff <= best_in;  min_gap_ff <= min_gap_in;  prev_ff <= prev_in;
      mf_ff <= mf_in;  ml_ff <= ml_in;  before_ff <= before_in;
      acc_ff <= acc_in;  hit_ff <= hit_in;  cursor_ff <= cursor_in;
      largest_ff <= largest_in;  written_ff <= written_in;  pend_v_ff <= pend_v_in;
      pend_first_ff <= pend_first_in;  pend_last_ff <= pend_last_in;  stcode_ff <= stcode_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> hdl/ict_ctrl.sv
`timescale 1ns / 1ps
module ict_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output ict_pkg::dp_cmd_type    cmd,
   input  ict_pkg::dp_status_type dp_status
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADD_FIRST,
      S_TAIL,
      S_APPEND,
      S_CO_SCAN,
      S_CO_MERGE,
      S_CO_COPY,
      S_SCAN,
      S_MG_COPY,
      S_INS,
      S_MEMBER,
      S_COUNT,
      S_GAP,
      S_GAP_TAIL,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      ret_scan_ff, ret_scan_in;

   // Next state and command
   always_comb begin
      state_in    = state_ff;
      ret_scan_in = ret_scan_ff;
      cmd.op      = ict_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.op = ict_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (dp_status.kind) inside
               ict_pkg::REQ_ADD: begin
                  if (dp_status.inverted) begin
                     cmd.op = ict_pkg::OP_BAD;
                     state_in = S_EMIT;
                  end else begin
                     cmd.op = ict_pkg::OP_ADD_START;
                     state_in = dp_status.store_empty ? S_ADD_FIRST : S_TAIL;
                  end
               end
               ict_pkg::REQ_MEMBER: state_in = S_MEMBER;
               ict_pkg::REQ_COUNT:  state_in = dp_status.inverted ? S_EMIT : S_COUNT;
               ict_pkg::REQ_GAPS, ict_pkg::REQ_LARGEST: begin
                  state_in = dp_status.inverted ? S_EMIT : S_GAP;
               end
               ict_pkg::REQ_CLEAR: begin
                  cmd.op = ict_pkg::OP_CLEAR;
                  state_in = S_EMIT;
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_ADD_FIRST: begin
            cmd.op = ict_pkg::OP_ADD_FIRST;
            state_in = S_EMIT;
         end
         S_TAIL: begin
            if (dp_status.tail_extend) begin
               cmd.op = ict_pkg::OP_TAIL;
               state_in = S_EMIT;
            end else if (dp_status.tail_after) begin
               if (dp_status.store_full) begin
                  cmd.op = ict_pkg::OP_CO_INIT;
                  ret_scan_in = 1'b0;
                  state_in = S_CO_SCAN;
               end else begin
                  state_in = S_APPEND;
               end
            end else begin
               cmd.op = ict_pkg::OP_SCAN_INIT;
               state_in = S_SCAN;
            end
         end
         S_APPEND: begin
            cmd.op = ict_pkg::OP_APPEND;
            state_in = S_EMIT;
         end
         S_CO_SCAN: begin
            cmd.op = ict_pkg::OP_CO_SCAN;
            if (dp_status.co_last) state_in = S_CO_MERGE;
         end
         S_CO_MERGE: begin
            cmd.op = ict_pkg::OP_CO_MERGE;
            state_in = S_CO_COPY;
         end
         S_CO_COPY: begin
            if (dp_status.scan_end) begin
               cmd.op = ict_pkg::OP_CO_DONE;
               state_in = ret_scan_ff ? S_SCAN : S_APPEND;
            end else begin
               cmd.op = ict_pkg::OP_COPY;
            end
         end
         S_SCAN: begin
            if (dp_status.scan_end || dp_status.scan_stop) begin
               if (dp_status.merge_found) begin
                  cmd.op = ict_pkg::OP_MG_WRITE;
                  state_in = S_MG_COPY;
               end else if (dp_status.store_full) begin
                  cmd.op = ict_pkg::OP_CO_INIT;
                  ret_scan_in = 1'b1;
                  state_in = S_CO_SCAN;
               end else begin
                  cmd.op = ict_pkg::OP_INS_INIT;
                  state_in = S_INS;
               end
            end else begin
               cmd.op = ict_pkg::OP_SCAN;
            end
         end
         S_MG_COPY: begin
            if (dp_status.scan_end) begin
               cmd.op = ict_pkg::OP_MG_DONE;
               state_in = S_EMIT;
            end else begin
               cmd.op = ict_pkg::OP_COPY;
            end
         end
         S_INS: begin
            cmd.op = ict_pkg::OP_INS;
            if (dp_status.ins_done) state_in = S_EMIT;
         end
         S_MEMBER: begin
            if (dp_status.scan_end) state_in = S_EMIT;
            else cmd.op = ict_pkg::OP_MEMBER;
         end
         S_COUNT: begin
            if (dp_status.scan_end) state_in = S_EMIT;
            else cmd.op = ict_pkg::OP_COUNT;
         end
         S_GAP: begin
            if (dp_status.scan_end || dp_status.gap_stop) state_in = S_GAP_TAIL;
            else cmd.op = ict_pkg::OP_GAP;
         end
         S_GAP_TAIL: begin
            if (dp_status.out_free) begin
               cmd.op = ict_pkg::OP_GAP_TAIL;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (dp_status.out_free) begin
               cmd.op = ict_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         ret_scan_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         ret_scan_ff  <= ret_scan_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

>>> hdl/interval_coverage_tracker.sv
`timescale 1ns / 1ps
// An add that meets a full store may scan, coalesce a pair, rescan and shift.
// Throughput: one item at a time; the store is walked one entry per cycle over
// its single read port, and gap lists emit one item per cycle, when not stalled.
// Reset: synchronous; empties the store, zeroes counters, flag and bounds.
module interval_coverage_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ict_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ict_pkg::rsp_item_type rsp_item
);

   ict_pkg::dp_cmd_type    cmd;
   ict_pkg::dp_status_type dp_status;

   ict_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   ict_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .dp_status (dp_status),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // An accepted item closes the input until its results are out
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input stayed open after accept");

   // The datapath only loads a new item while the controller is idle
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (cmd.op == ict_pkg::OP_NONE || cmd.op == ict_pkg::OP_LOAD))
      else $error("datapath busy while idle");

   // Store never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.interval_count <= 6'(ict_pkg::CAPACITY)))
      else $error("interval count beyond capacity");

   // Covered total saturates
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.total_covered <= ict_pkg::TOTAL_CAP))
      else $error("covered total beyond saturation");

endmodule

>>> verif/interval_coverage_checker.sv
`timescale 1ns / 1ps
module interval_coverage_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  ict_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ict_pkg::rsp_item_type rsp_item,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int unsigned DEPTH = ict_pkg::CAPACITY;

   // Predicted store and counters
   logic [31:0] iv_first [DEPTH];
   logic [31:0] iv_last [DEPTH];
   int unsigned iv_count;
   logic [32:0] cov_total;
   logic [31:0] drop_total;
   logic        ovf_seen;
   logic        bnd_seen;
   logic [31:0] bnd_low;
   logic [31:0] bnd_high;

   ict_pkg::rsp_item_type expected_rsps [$];

   function automatic void clear_store();
      iv_count   = 0;
      cov_total  = '0;
      drop_total = '0;
      ovf_seen   = 1'b0;
      bnd_seen   = 1'b0;
      bnd_low    = '0;
      bnd_high   = '0;
   endfunction

   function automatic logic [32:0] width_of(logic [31:0] a, logic [31:0] b);
      return {1'b0, b} - {1'b0, a} + 33'd1;
   endfunction

   function automatic void raise_total(logic [32:0] d);
      logic [33:0] s;
      s = {1'b0, cov_total} + {1'b0, d};
      cov_total = (s > {1'b0, ict_pkg::TOTAL_CAP}) ? ict_pkg::TOTAL_CAP : s[32:0];
   endfunction

   // Merge the closest neighbor pair; first pair wins a tie
   function automatic void merge_closest();
      int unsigned best;
      logic [32:0] min_gap, g;
      best = 0;
      min_gap = '1;
      if (iv_count < 2) return;
      for (int unsigned i = 0; i + 1 < iv_count; i++) begin
         g = {1'b0, iv_first[i+1]} - {1'b0, iv_last[i]};
         if (g < min_gap) begin
            min_gap = g;
            best = i;
         end
      end
      iv_last[best] = iv_last[best+1];
      for (int unsigned i = best + 1; i + 1 < iv_count; i++) begin
         iv_first[i] = iv_first[i+1];
         iv_last[i]  = iv_last[i+1];
      end
      iv_count--;
      if (drop_total != 32'hFFFF_FFFF) drop_total++;
      ovf_seen = 1'b1;
   endfunction

   function automatic logic [1:0] insert_interval(logic [31:0] a, logic [31:0] b);
      int unsigned n, pos, me;
      logic [31:0] mf, ml;
      logic [32:0] prior;
      if (a > b) return ict_pkg::STATUS_INVERTED;
      if (!bnd_seen) begin
         bnd_seen = 1'b1;
         bnd_low  = a;
         bnd_high = b;
      end else begin
         if (a < bnd_low) bnd_low = a;
         if (b > bnd_high) bnd_high = b;
      end
      n = iv_count;
      if (n == 0) begin
         iv_first[0] = a;
         iv_last[0]  = b;
         iv_count    = 1;
         raise_total(width_of(a, b));
         return ict_pkg::STATUS_OK;
      end
      // Tail extension or append
      if (a >= iv_first[n-1] && {1'b0, a} <= {1'b0, iv_last[n-1]} + 33'd1) begin
         if (b > iv_last[n-1]) begin
            raise_total({1'b0, b} - {1'b0, iv_last[n-1]});
            iv_last[n-1] = b;
         end
         return ict_pkg::STATUS_OK;
      end
      if ({1'b0, a} > {1'b0, iv_last[n-1]} + 33'd1) begin
         if (iv_count >= DEPTH) begin
            merge_closest();
            if (iv_count >= DEPTH) return ict_pkg::STATUS_FULL;
         end
         iv_first[iv_count] = a;
         iv_last[iv_count]  = b;
         iv_count++;
         raise_total(width_of(a, b));
         return ict_pkg::STATUS_OK;
      end
      // Splice with a fresh search after any coalesce
      forever begin
         n = iv_count;
         pos = 0;
         while (pos < n && {1'b0, iv_last[pos]} + 33'd1 < {1'b0, a}) pos++;
         me = pos;
         while (me < n && {1'b0, iv_first[me]} <= {1'b0, b} + 33'd1) me++;
         if (me > pos) begin
            mf = a;
            ml = b;
            prior = '0;
            for (int unsigned i = pos; i < me; i++) begin
               if (iv_first[i] < mf) mf = iv_first[i];
               if (iv_last[i] > ml) ml = iv_last[i];
               prior += width_of(iv_first[i], iv_last[i]);
            end
            iv_first[pos] = mf;
            iv_last[pos]  = ml;
            for (int unsigned i = me; i < n; i++) begin
               iv_first[pos + 1 + i - me] = iv_first[i];
               iv_last[pos + 1 + i - me]  = iv_last[i];
            end
            iv_count = n - (me - pos - 1);
            raise_total(width_of(mf, ml) - prior);
            return ict_pkg::STATUS_OK;
         end
         if (n >= DEPTH) begin
            merge_closest();
            if (iv_count >= DEPTH) return ict_pkg::STATUS_FULL;
            continue;
         end
         for (int unsigned i = n; i > pos; i--) begin
            iv_first[i] = iv_first[i-1];
            iv_last[i]  = iv_last[i-1];
         end
         iv_first[pos] = a;
         iv_last[pos]  = b;
         iv_count = n + 1;
         raise_total(width_of(a, b));
         return ict_pkg::STATUS_OK;
      end
   endfunction

   function automatic void push_rsp(logic [1:0] st, logic fnd, logic [32:0] ans,
                                    logic [31:0] gf, logic [31:0] gl, logic fin);
      ict_pkg::rsp_item_type r;
      r.status         = st;
      r.found          = fnd;
      r.answer         = ans;
      r.gap_first      = gf;
      r.gap_last       = gl;
      r.last_result    = fin;
      r.total_covered  = cov_total;
      r.interval_count = iv_count[5:0];
      r.dropped_count  = drop_total;
      r.overflow_flag  = ovf_seen;
      r.bound_low      = bnd_low;
      r.bound_high     = bnd_high;
      expected_rsps.push_back(r);
   endfunction

   function automatic void predict_request(ict_pkg::req_item_type q);
      logic [31:0] lo, hi, a, b;
      logic [32:0] tot, cursor, largest, g;
      logic [31:0] gf [$];
      logic [31:0] gl [$];
      int unsigned limit;
      logic hit;
      lo = q.lo_index;
      hi = q.hi_index;
      case (q.req_type)
         ict_pkg::REQ_ADD: begin
            push_rsp(insert_interval(lo, hi), 1'b0, '0, '0, '0, 1'b1);
         end
         ict_pkg::REQ_MEMBER: begin
            hit = 1'b0;
            for (int unsigned i = 0; i < iv_count; i++)
               if (lo >= iv_first[i] && lo <= iv_last[i]) hit = 1'b1;
            push_rsp(ict_pkg::STATUS_OK, hit, '0, '0, '0, 1'b1);
         end
         ict_pkg::REQ_COUNT: begin
            tot = '0;
            if (lo <= hi) begin
               for (int unsigned i = 0; i < iv_count; i++) begin
                  a = iv_first[i] > lo ? iv_first[i] : lo;
                  b = iv_last[i] < hi ? iv_last[i] : hi;
                  if (a <= b) tot += width_of(a, b);
               end
            end
            push_rsp(ict_pkg::STATUS_OK, 1'b0, tot, '0, '0, 1'b1);
         end
         ict_pkg::REQ_GAPS, ict_pkg::REQ_LARGEST: begin
            limit = 32'(q.max_gaps);
            if (q.req_type == ict_pkg::REQ_LARGEST || limit > ict_pkg::GAP_LIMIT)
               limit = ict_pkg::GAP_LIMIT;
            cursor = {1'b0, lo};
            largest = '0;
            if (lo <= hi) begin
               for (int unsigned i = 0; i < iv_count && gf.size() < limit; i++) begin
                  a = iv_first[i];
                  b = iv_last[i];
                  if (b < lo) continue;
                  if (a > hi) break;
                  if ({1'b0, a} > cursor) begin
                     g = {1'b0, a} - cursor;
                     if (g > largest) largest = g;
                     gf.push_back(cursor[31:0]);
                     gl.push_back(a - 32'd1);
                  end
                  if ({1'b0, b} + 33'd1 > cursor) cursor = {1'b0, b} + 33'd1;
               end
               if (gf.size() < limit && cursor <= {1'b0, hi}) begin
                  g = {1'b0, hi} - cursor + 33'd1;
                  if (g > largest) largest = g;
                  gf.push_back(cursor[31:0]);
                  gl.push_back(hi);
               end
            end
            if (q.req_type == ict_pkg::REQ_LARGEST) begin
               if (largest > ict_pkg::GAP_SAT) largest = ict_pkg::GAP_SAT;
               push_rsp(ict_pkg::STATUS_OK, 1'b0, largest, '0, '0, 1'b1);
            end else if (gf.size() == 0) begin
               push_rsp(ict_pkg::STATUS_OK, 1'b0, '0, '0, '0, 1'b1);
            end else begin
               foreach (gf[i])
                  push_rsp(ict_pkg::STATUS_OK, 1'b1, '0, gf[i], gl[i], i == gf.size() - 1);
            end
         end
         ict_pkg::REQ_CLEAR: begin
            clear_store();
            push_rsp(ict_pkg::STATUS_OK, 1'b0, '0, '0, '0, 1'b1);
         end
         default: begin
            push_rsp(ict_pkg::STATUS_OK, 1'b0, '0, '0, '0, 1'b1);
         end
      endcase
   endfunction

   // Predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      ict_pkg::rsp_item_type want;
      if (reset) begin
         clear_store();
         expected_rsps.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result item %p", $time, rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_item);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_request(req_item);
         pending_count <= expected_rsps.size();
      end
   end

endmodule

>>> verif/interval_coverage_tracker_test.sv
`timescale 1ns / 1ps
module interval_coverage_tracker_test;

   localparam int RANDOM_ITEMS = 235;
   localparam int CYCLE_LIMIT  = 400000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   ict_pkg::req_item_type req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   ict_pkg::rsp_item_type rsp_item;
   int                    fail_count;
   int                    pending_count;
   int                    cycle_count = 0;
   bit                    calm_phase = 0;
   bit                    hold_off = 0;

   always #5 clock = ~clock;

   interval_coverage_tracker u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   interval_coverage_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Runaway guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side: random stall bursts, plus one long hold-off
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 4);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_req(logic [2:0] kind, logic [31:0] lo, logic [31:0] hi,
                           logic [6:0] gaps);
      int n;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         n = $urandom_range(1, 4);
         repeat (n) @(negedge clock);
      end
      req_valid <= 1;
      req_item  <= '{req_type: kind, lo_index: lo, hi_index: hi, max_gaps: gaps};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly small indices so intervals touch, overlap and fill the store
   function automatic logic [31:0] pick_index();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'hFFFF_FFFF - $urandom_range(0, 20);
         default: return $urandom_range(0, 400);
      endcase
   endfunction

   initial begin
      logic [31:0] lo, hi;
      logic [2:0]  kind;
      repeat (11) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: extremes, inverted add, queries on empty store, each op
      send_req(ict_pkg::REQ_GAPS, 0, 32'hFFFF_FFFF, 7'd127);
      send_req(ict_pkg::REQ_LARGEST, 0, 32'hFFFF_FFFF, 7'd1);
      send_req(ict_pkg::REQ_ADD, 10, 5, 7'd0);
      send_req(ict_pkg::REQ_ADD, 0, 32'hFFFF_FFFF, 7'd0);
      send_req(ict_pkg::REQ_COUNT, 0, 32'hFFFF_FFFF, 7'd0);
      send_req(ict_pkg::REQ_MEMBER, 32'hFFFF_FFFF, 0, 7'd0);
      send_req(ict_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
      send_req(ict_pkg::REQ_ADD, 100, 200, 7'd0);
      send_req(ict_pkg::REQ_ADD, 150, 300, 7'd0);
      send_req(ict_pkg::REQ_ADD, 301, 310, 7'd0);
      send_req(ict_pkg::REQ_ADD, 10, 20, 7'd0);
      send_req(ict_pkg::REQ_ADD, 22, 99, 7'd0);
      send_req(ict_pkg::REQ_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 7'd0);
      send_req(ict_pkg::REQ_GAPS, 0, 32'hFFFF_FFFF, 7'd64);
      send_req(ict_pkg::REQ_GAPS, 0, 32'hFFFF_FFFF, 7'd0);
      send_req(ict_pkg::REQ_GAPS, 50, 40, 7'd5);
      send_req(ict_pkg::REQ_COUNT, 15, 305, 7'd0);
      send_req(ict_pkg::REQ_LARGEST, 5, 3, 7'd0);
      send_req(3'd6, 1, 2, 7'd3);
      send_req(3'd7, 1, 2, 7'd3);
      // Fill the store past capacity with spaced intervals, then splice
      for (int i = 0; i < 40; i++)
         send_req(ict_pkg::REQ_ADD, 32'(1000 + i * 10), 32'(1003 + i * 10), 7'd0);
      send_req(ict_pkg::REQ_ADD, 1005, 1005, 7'd0);
      send_req(ict_pkg::REQ_ADD, 500, 500, 7'd0);
      send_req(ict_pkg::REQ_GAPS, 0, 32'hFFFF_FFFF, 7'd127);

      // Long receiver hold-off while items keep coming
      hold_off = 1;
      for (int i = 0; i < 12; i++) send_req(ict_pkg::REQ_GAPS, 0, 2000, 7'd40);

      // Random part
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 40) calm_phase = 1;
         lo = pick_index();
         hi = ($urandom_range(0, 9) == 0) ? pick_index() : lo + $urandom_range(0, 30);
         if (hi < lo && $urandom_range(0, 3) != 0) hi = lo;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: kind = ict_pkg::REQ_ADD;
            8, 9: kind = ict_pkg::REQ_MEMBER;
            10, 11: kind = ict_pkg::REQ_COUNT;
            12, 13, 14: kind = ict_pkg::REQ_GAPS;
            15, 16: kind = ict_pkg::REQ_LARGEST;
            17: kind = ($urandom_range(0, 3) == 0) ? ict_pkg::REQ_CLEAR : ict_pkg::REQ_ADD;
            default: kind = 3'($urandom_range(0, 7));
         endcase
         if (kind == ict_pkg::REQ_GAPS || kind == ict_pkg::REQ_COUNT ||
             kind == ict_pkg::REQ_LARGEST) begin
            if ($urandom_range(0, 2) == 0) begin
               lo = $urandom_range(0, 200);
               hi = $urandom_range(300, 3000);
            end
         end
         send_req(kind, lo, hi, 7'($urandom_range(0, 127)));
      end
      req_valid <= 0;

      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
